>>> rtl/psw_pkg.sv
// ----------------------------------------------------------------------------
// psw_pkg
// Shared constants, register map, configuration type and helper functions
// for the pulse and damped sine waveform source.
// ----------------------------------------------------------------------------
package psw_pkg;

  localparam int TIME_W     = 32;
  localparam int SAMPLE_W   = 16;
  localparam int PHASE_W    = 32;
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 5;
  localparam int MOD_STAGES = TIME_W;
  localparam int DIV_STAGES = SAMPLE_W;
  localparam int PULSE_LAT  = 4 + MOD_STAGES + DIV_STAGES;
  localparam int SINE_LAT   = 9;
  localparam int LOG2E_Q16  = 94548;

  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_BASE   = 3'd1;
  localparam logic [2:0] REG_PEAK   = 3'd2;
  localparam logic [2:0] REG_DELAY  = 3'd3;
  localparam logic [2:0] REG_RISE   = 3'd4;
  localparam logic [2:0] REG_FALL   = 3'd5;
  localparam logic [2:0] REG_WIDTH  = 3'd6;
  localparam logic [2:0] REG_PERIOD = 3'd7;

  localparam logic [1:0] SEG_RISE = 2'd0;
  localparam logic [1:0] SEG_HOLD = 2'd1;
  localparam logic [1:0] SEG_FALL = 2'd2;
  localparam logic [1:0] SEG_REST = 2'd3;

  typedef struct packed {
    logic                       wave_mode;
    logic signed [SAMPLE_W-1:0] base_level;
    logic signed [SAMPLE_W-1:0] peak_level;
    logic [TIME_W-1:0]          start_delay;
    logic [TIME_W-1:0]          rise_or_phase_step;
    logic [TIME_W-1:0]          fall_or_decay;
    logic [TIME_W-1:0]          pulse_width;
    logic [TIME_W-1:0]          pulse_period;
  } cfg_t;

  // 2^(-j/16) in q16
  function automatic logic [16:0] exp2_frac(input logic [4:0] idx);
    logic [16:0] v;
    case (idx)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      5'd16:   v = 17'd32768;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat_sample(
    input logic signed [SAMPLE_W+1:0] v);
    logic [2:0] top;
    top = v[SAMPLE_W+1:SAMPLE_W-1];
    if (top == 3'b000 || top == 3'b111) begin
      return v[SAMPLE_W-1:0];
    end else if (v[SAMPLE_W+1]) begin
      return {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  endfunction

endpackage

>>> rtl/pulse_sine_waveform_generator.sv
// ----------------------------------------------------------------------------
// pulse_sine_waveform_generator
// Pulse or damped sine source level for one time query per transfer.
// ----------------------------------------------------------------------------
// level is registered behind t0 and the pulse and sine pipelines
// throughput: one query per cycle unless level stalls; the 32-stage remainder
//   divider and the 16-stage ramp divider are fully pipelined
// a stall on level freezes the whole pipeline
// reset clears the valid pipeline and the configuration registers to zero
module pulse_sine_waveform_generator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [psw_pkg::ADDR_W-1:0]          paddr,
  input  logic [psw_pkg::DATA_W-1:0]          pwdata,
  output logic [psw_pkg::DATA_W-1:0]          prdata,
  output logic                                pready,
  input  logic                                tick_valid,
  output logic                                tick_ready,
  input  logic [psw_pkg::TIME_W-1:0]          time_tick,
  output logic                                level_valid,
  input  logic                                level_ready,
  output logic signed [psw_pkg::SAMPLE_W-1:0] level
);
  import psw_pkg::*;

  localparam int LAT = PULSE_LAT + 2;

  cfg_t                       cfg;
  logic [LAT-1:0]             vld;
  logic                       en;
  logic [TIME_W-1:0]          t0;
  logic signed [SAMPLE_W-1:0] pulse_lvl;
  logic signed [SAMPLE_W-1:0] sine_lvl;

  assign pready      = 1'b1;
  assign en          = !vld[LAT-1] || level_ready;
  assign tick_ready  = en;
  assign level_valid = vld[LAT-1];

  psw_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], tick_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t0    <= time_tick;
      level <= cfg.wave_mode ? sine_lvl : pulse_lvl;
    end
  end

  psw_pulse u_pulse (
    .clk (clk),
    .en  (en),
    .cfg (cfg),
    .t   (t0),
    .lvl (pulse_lvl)
  );

  psw_sine u_sine (
    .clk (clk),
    .en  (en),
    .cfg (cfg),
    .t   (t0),
    .lvl (sine_lvl)
  );

endmodule

>>> rtl/psw_regs.sv
// ----------------------------------------------------------------------------
// psw_regs
// Configuration register file behind an APB-style port.
// ----------------------------------------------------------------------------
module psw_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [psw_pkg::ADDR_W-1:0]  paddr,
  input  logic [psw_pkg::DATA_W-1:0]  pwdata,
  output logic [psw_pkg::DATA_W-1:0]  prdata,
  output psw_pkg::cfg_t               cfg
);
  import psw_pkg::*;

  logic [2:0] idx;
  logic       wr;

  assign idx = paddr[ADDR_W-1:2];
  assign wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_MODE:   cfg.wave_mode          <= pwdata[0];
        REG_BASE:   cfg.base_level         <= pwdata[SAMPLE_W-1:0];
        REG_PEAK:   cfg.peak_level         <= pwdata[SAMPLE_W-1:0];
        REG_DELAY:  cfg.start_delay        <= pwdata[TIME_W-1:0];
        REG_RISE:   cfg.rise_or_phase_step <= pwdata[TIME_W-1:0];
        REG_FALL:   cfg.fall_or_decay      <= pwdata[TIME_W-1:0];
        REG_WIDTH:  cfg.pulse_width        <= pwdata[TIME_W-1:0];
        REG_PERIOD: cfg.pulse_period       <= pwdata[TIME_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MODE:   prdata = DATA_W'(cfg.wave_mode);
      REG_BASE:   prdata = DATA_W'(unsigned'(cfg.base_level));
      REG_PEAK:   prdata = DATA_W'(unsigned'(cfg.peak_level));
      REG_DELAY:  prdata = DATA_W'(cfg.start_delay);
      REG_RISE:   prdata = DATA_W'(cfg.rise_or_phase_step);
      REG_FALL:   prdata = DATA_W'(cfg.fall_or_decay);
      REG_WIDTH:  prdata = DATA_W'(cfg.pulse_width);
      REG_PERIOD: prdata = DATA_W'(cfg.pulse_period);
    endcase
  end

endmodule

>>> rtl/psw_pulse.sv
// ----------------------------------------------------------------------------
// psw_pulse
// Pulse shape pipeline: pipelined remainder divider for the position in the
// period, segment decode, ramp product and pipelined ramp divider.
// ----------------------------------------------------------------------------
module psw_pulse (
  input  logic                               clk,
  input  logic                               en,
  input  psw_pkg::cfg_t                      cfg,
  input  logic [psw_pkg::TIME_W-1:0]         t,
  output logic signed [psw_pkg::SAMPLE_W-1:0] lvl
);
  import psw_pkg::*;

  localparam int RW = TIME_W + 2;
  localparam int MW = SAMPLE_W + TIME_W;

  logic [RW-1:0] sum_rw;
  logic [RW-1:0] sum_rwf;
  logic [RW-1:0] per_eff;

  assign sum_rw  = RW'(cfg.rise_or_phase_step) + RW'(cfg.pulse_width);
  assign sum_rwf = sum_rw + RW'(cfg.fall_or_decay);
  assign per_eff = (cfg.pulse_period != '0) ? RW'(cfg.pulse_period) : sum_rwf;

  // entry stage
  logic [TIME_W-1:0] dt0;
  logic              rest0;

  always_ff @(posedge clk) begin
    if (en) begin
      dt0   <= t - cfg.start_delay;
      rest0 <= (t < cfg.start_delay) || (per_eff == '0);
    end
  end

  // remainder divider, one dividend bit a stage
  logic [RW-1:0]     rem_q  [MOD_STAGES];
  logic [TIME_W-1:0] mdt_q  [MOD_STAGES];
  logic              mrest_q[MOD_STAGES];

  for (genvar k = 0; k < MOD_STAGES; k++) begin : g_mod
    logic [RW-1:0]     rin;
    logic [TIME_W-1:0] din;
    logic              fin;
    logic [RW:0]       sh;
    logic [RW:0]       sub;
    if (k == 0) begin : g_first
      assign rin = '0;
      assign din = dt0;
      assign fin = rest0;
    end else begin : g_next
      assign rin = rem_q[k-1];
      assign din = mdt_q[k-1];
      assign fin = mrest_q[k-1];
    end
    assign sh  = {rin, din[TIME_W-1-k]};
    assign sub = sh - {1'b0, per_eff};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]   <= (sh >= {1'b0, per_eff}) ? sub[RW-1:0] : sh[RW-1:0];
        mdt_q[k]   <= din;
        mrest_q[k] <= fin;
      end
    end
  end

  // segment decode
  logic [TIME_W-1:0] pos;
  logic [RW-1:0]     pos_w;
  logic [RW-1:0]     off_f;
  logic [1:0]        cseg;
  logic [TIME_W-1:0] coff;

  assign pos   = rem_q[MOD_STAGES-1][TIME_W-1:0];
  assign pos_w = RW'(pos);
  assign off_f = pos_w - sum_rw;

  always_ff @(posedge clk) begin
    if (en) begin
      if (mrest_q[MOD_STAGES-1]) begin
        cseg <= SEG_REST;
      end else if (pos < cfg.rise_or_phase_step) begin
        cseg <= SEG_RISE;
      end else if (pos_w < sum_rw) begin
        cseg <= SEG_HOLD;
      end else if (pos_w < sum_rwf) begin
        cseg <= SEG_FALL;
      end else begin
        cseg <= SEG_REST;
      end
      coff <= (pos < cfg.rise_or_phase_step) ? pos : off_f[TIME_W-1:0];
    end
  end

  // ramp product
  logic signed [SAMPLE_W:0] diff;
  logic [SAMPLE_W-1:0]      dmag;
  logic [SAMPLE_W:0]        dneg;
  logic [MW-1:0]            pmag;
  logic [TIME_W-1:0]        pden;
  logic                     pneg;
  logic [1:0]               pseg;

  assign diff = (SAMPLE_W+1)'(cfg.peak_level) - (SAMPLE_W+1)'(cfg.base_level);
  assign dneg = -diff;
  assign dmag = diff[SAMPLE_W] ? dneg[SAMPLE_W-1:0] : diff[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      pmag <= MW'(dmag) * MW'(coff);
      pden <= (cseg == SEG_RISE) ? cfg.rise_or_phase_step : cfg.fall_or_decay;
      pneg <= (cseg == SEG_RISE) ? diff[SAMPLE_W] : (!diff[SAMPLE_W] && diff != '0);
      pseg <= cseg;
    end
  end

  // ramp divider, one quotient bit a stage
  logic [TIME_W-1:0]     drem_q[DIV_STAGES];
  logic [DIV_STAGES-1:0] dq_q  [DIV_STAGES];
  logic [SAMPLE_W-1:0]   dlo_q [DIV_STAGES];
  logic [TIME_W-1:0]     dden_q[DIV_STAGES];
  logic                  dneg_q[DIV_STAGES];
  logic [1:0]            dseg_q[DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    logic [TIME_W-1:0]     rin;
    logic [DIV_STAGES-1:0] qin;
    logic [SAMPLE_W-1:0]   lin;
    logic [TIME_W-1:0]     den;
    logic                  nin;
    logic [1:0]            sin;
    logic [TIME_W:0]       sh;
    logic [TIME_W:0]       sub;
    logic                  hit;
    if (j == 0) begin : g_first
      assign rin = pmag[MW-1:SAMPLE_W];
      assign qin = '0;
      assign lin = pmag[SAMPLE_W-1:0];
      assign den = pden;
      assign nin = pneg;
      assign sin = pseg;
    end else begin : g_next
      assign rin = drem_q[j-1];
      assign qin = dq_q[j-1];
      assign lin = dlo_q[j-1];
      assign den = dden_q[j-1];
      assign nin = dneg_q[j-1];
      assign sin = dseg_q[j-1];
    end
    assign sh  = {rin, lin[SAMPLE_W-1-j]};
    assign sub = sh - {1'b0, den};
    assign hit = (sh >= {1'b0, den});
    always_ff @(posedge clk) begin
      if (en) begin
        drem_q[j] <= hit ? sub[TIME_W-1:0] : sh[TIME_W-1:0];
        dq_q[j]   <= {qin[DIV_STAGES-2:0], hit};
        dlo_q[j]  <= lin;
        dden_q[j] <= den;
        dneg_q[j] <= nin;
        dseg_q[j] <= sin;
      end
    end
  end

  // level select
  logic signed [SAMPLE_W+1:0] qs;
  logic signed [SAMPLE_W+1:0] fsum;
  logic signed [SAMPLE_W+1:0] base_x;
  logic signed [SAMPLE_W+1:0] peak_x;

  assign base_x = (SAMPLE_W+2)'(cfg.base_level);
  assign peak_x = (SAMPLE_W+2)'(cfg.peak_level);
  assign qs = dneg_q[DIV_STAGES-1] ? -$signed((SAMPLE_W+2)'(dq_q[DIV_STAGES-1]))
                                   :  $signed((SAMPLE_W+2)'(dq_q[DIV_STAGES-1]));

  always_comb begin
    unique case (dseg_q[DIV_STAGES-1])
      SEG_RISE: fsum = base_x + qs;
      SEG_HOLD: fsum = peak_x;
      SEG_FALL: fsum = peak_x + qs;
      SEG_REST: fsum = base_x;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lvl <= sat_sample(fsum);
    end
  end

endmodule

>>> rtl/psw_sine.sv
// ----------------------------------------------------------------------------
// psw_sine
// Damped sine pipeline: phase and decay exponent products, quarter-wave
// polynomial, exp2 table interpolation, scaling and offset, then a delay
// line that lines the result up with the pulse pipeline.
// ----------------------------------------------------------------------------
module psw_sine (
  input  logic                                clk,
  input  logic                                en,
  input  psw_pkg::cfg_t                       cfg,
  input  logic [psw_pkg::TIME_W-1:0]          t,
  output logic signed [psw_pkg::SAMPLE_W-1:0] lvl
);
  import psw_pkg::*;

  localparam int DLY = PULSE_LAT - SINE_LAT;

  // stage 1
  logic [TIME_W-1:0] dt1;
  logic              bef1;
  // stage 2
  logic [PHASE_W-1:0] ph2;
  logic               big2;
  logic [19:0]        e2;
  logic               bef2;
  // stage 3
  logic [1:0]  quad3;
  logic [16:0] u3;
  logic [20:0] y3;
  logic        big3;
  logic        bef3;
  // stage 4
  logic [1:0]  quad4;
  logic [16:0] u4;
  logic [16:0] u2_4;
  logic [4:0]  n4;
  logic [16:0] tb4;
  logic [16:0] ti4;
  logic        big4;
  logic        bef4;
  // stage 5
  logic [1:0]  quad5;
  logic [16:0] u5;
  logic [16:0] u2_5;
  logic [15:0] a5;
  logic [16:0] dec5;
  logic        bef5;
  // stage 6
  logic [1:0]  quad6;
  logic [16:0] u6;
  logic [16:0] a2_6;
  logic [16:0] dec6;
  logic        bef6;
  // stage 7
  logic [1:0]  quad7;
  logic [16:0] s7;
  logic [16:0] dec7;
  logic        bef7;
  // stage 8
  logic        neg8;
  logic [16:0] m8;
  logic        bef8;

  logic [63:0] e_full;
  logic [15:0] u0;
  logic [16:0] dtab;
  logic [16:0] val4;

  assign e_full = 64'(cfg.fall_or_decay) * 64'(dt1);
  assign u0     = ph2[29:14];
  assign dtab   = exp2_frac({1'b0, y3[15:12]}) - exp2_frac(5'(y3[15:12]) + 5'd1);
  assign val4   = tb4 - ti4;

  always_ff @(posedge clk) begin
    if (en) begin
      dt1   <= t - cfg.start_delay;
      bef1  <= t < cfg.start_delay;

      ph2   <= cfg.rise_or_phase_step * dt1;
      big2  <= |e_full[63:20];
      e2    <= e_full[19:0];
      bef2  <= bef1;

      quad3 <= ph2[31:30];
      u3    <= ph2[30] ? 17'h10000 - 17'(u0) : 17'(u0);
      y3    <= 21'((38'(e2) * 38'(LOG2E_Q16)) >> 16);
      big3  <= big2;
      bef3  <= bef2;

      quad4 <= quad3;
      u4    <= u3;
      u2_4  <= 17'((34'(u3) * 34'(u3)) >> 16);
      n4    <= y3[20:16];
      tb4   <= exp2_frac({1'b0, y3[15:12]});
      ti4   <= 17'((29'(dtab) * 29'(y3[11:0])) >> 12);
      big4  <= big3;
      bef4  <= bef3;

      quad5 <= quad4;
      u5    <= u4;
      u2_5  <= u2_4;
      a5    <= 16'(17'd42048 - 17'((34'(4640) * 34'(u2_4)) >> 16));
      dec5  <= big4 ? 17'd0 : (val4 >> n4);
      bef5  <= bef4;

      quad6 <= quad5;
      u6    <= u5;
      a2_6  <= 17'd102944 - 17'((33'(a5) * 33'(u2_5)) >> 16);
      dec6  <= dec5;
      bef6  <= bef5;

      quad7 <= quad6;
      s7    <= 17'((34'(a2_6) * 34'(u6)) >> 16);
      dec7  <= dec6;
      bef7  <= bef6;

      neg8  <= quad7[1];
      m8    <= 17'((34'(dec7) * 34'(s7)) >> 16);
      bef8  <= bef7;
    end
  end

  // stage 9: scale, round, offset
  logic signed [33:0]         prod;
  logic signed [33:0]         prod_s;
  logic signed [33:0]         rnd;
  logic signed [SAMPLE_W+1:0] ssum;
  logic signed [SAMPLE_W-1:0] lvl9;

  assign prod   = 34'(cfg.peak_level) * $signed({17'b0, m8});
  assign prod_s = neg8 ? -prod : prod;
  assign rnd    = prod_s + 34'sd32768;
  assign ssum   = (SAMPLE_W+2)'(cfg.base_level) + $signed(rnd[33:16]);

  always_ff @(posedge clk) begin
    if (en) begin
      lvl9 <= bef8 ? cfg.base_level : sat_sample(ssum);
    end
  end

  // alignment delay
  logic signed [SAMPLE_W-1:0] dly[DLY];

  for (genvar k = 0; k < DLY; k++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en) begin
        dly[k] <= (k == 0) ? lvl9 : dly[(k == 0) ? 0 : k-1];
      end
    end
  end

  assign lvl = dly[DLY-1];

endmodule

>>> rtl/psw_check.sv
// ----------------------------------------------------------------------------
// psw_check
// Port-level checks for the waveform source, bound to the top level.
// ----------------------------------------------------------------------------
module psw_check (
  input logic                                clk,
  input logic                                rst,
  input logic                                pready,
  input logic                                tick_ready,
  input logic                                level_valid,
  input logic                                level_ready,
  input logic signed [psw_pkg::SAMPLE_W-1:0] level
);

  a_reset_empty : assert property (@(posedge clk) rst |=> !level_valid)
    else $error("level valid after reset");

  a_hold : assert property (@(posedge clk) disable iff (rst)
    level_valid && !level_ready |=> level_valid && $stable(level))
    else $error("stalled level transfer changed");

  a_empty_takes : assert property (@(posedge clk) disable iff (rst)
    !level_valid |-> tick_ready)
    else $error("input refused with empty output");

  a_drain_takes : assert property (@(posedge clk) disable iff (rst)
    level_valid && level_ready |-> tick_ready)
    else $error("input refused while output drains");

  a_pready : assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind pulse_sine_waveform_generator psw_check u_psw_check (.*);

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives time queries into the pulse / damped sine source under several
// register settings written over the register port, predicts each level and
// checks every output transfer in order against the predicted levels.
// ----------------------------------------------------------------------------
module tb_top;
  import psw_pkg::*;

  localparam int DRAIN_CYCLES = 80;
  localparam int WATCHDOG_MAX = 20000;

  logic                       clk;
  logic                       rst;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [ADDR_W-1:0]          paddr;
  logic [DATA_W-1:0]          pwdata;
  logic [DATA_W-1:0]          prdata;
  logic                       pready;
  logic                       tick_valid;
  logic                       tick_ready;
  logic [TIME_W-1:0]          time_tick;
  logic                       level_valid;
  logic                       level_ready;
  logic signed [SAMPLE_W-1:0] level;

  cfg_t                       shadow_cfg;
  logic [TIME_W-1:0]          pending_ticks[$];
  logic signed [SAMPLE_W-1:0] expected_levels[$];
  int                         error_count;
  int                         level_count;
  int                         idle_cycles;
  int                         burst_left;
  int                         gap_left;
  int                         hold_off;
  int                         stall_phase;
  bit                         hold_request;
  int                         phase_count;

  pulse_sine_waveform_generator i_dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .tick_valid(tick_valid), .tick_ready(tick_ready), .time_tick(time_tick),
    .level_valid(level_valid), .level_ready(level_ready), .level(level)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic longint sat16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint trapezoid(input cfg_t c, input longint unsigned t);
    longint base, peak;
    longint unsigned per, pos;
    base = c.base_level;
    peak = c.peak_level;
    if (t < c.start_delay) return base;
    per = c.pulse_period;
    if (per == 0) per = longint'(c.rise_or_phase_step) + c.pulse_width + c.fall_or_decay;
    if (per == 0) return base;
    pos = (t - c.start_delay) % per;
    if (pos < c.rise_or_phase_step)
      return base + ((peak - base) * longint'(pos)) / longint'(c.rise_or_phase_step);
    pos -= c.rise_or_phase_step;
    if (pos < c.pulse_width) return peak;
    pos -= c.pulse_width;
    if (pos < c.fall_or_decay)
      return peak + ((base - peak) * longint'(pos)) / longint'(c.fall_or_decay);
    return base;
  endfunction

  function automatic longint unsigned decay_gain(input longint unsigned dt,
                                                 input longint unsigned rate);
    longint unsigned fracs[17];
    longint unsigned e, y, n, fr, idx, rem, val;
    fracs = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393, 46341,
              44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};
    if (rate == 0) return 65536;
    if (dt > ((64'd1 << 20) - 1) / rate) return 0;
    e = dt * rate;
    y = (e * 94548) >> 16;
    n = y >> 16;
    fr = y & 16'hFFFF;
    idx = fr >> 12;
    rem = fr & 12'hFFF;
    val = fracs[idx] - (((fracs[idx] - fracs[idx+1]) * rem) >> 12);
    if (n >= 32) return 0;
    return val >> n;
  endfunction

  function automatic longint damped_sine(input cfg_t c, input longint unsigned t);
    longint unsigned dt, ph, quad, u, u2, a, s, m;
    longint prod, amp;
    if (t < c.start_delay) return longint'(c.base_level);
    amp = c.peak_level;
    dt = t - c.start_delay;
    ph = (longint'(c.rise_or_phase_step) * dt) & 32'hFFFFFFFF;
    quad = ph >> 30;
    u = (ph >> 14) & 16'hFFFF;
    if (quad[0]) u = 65536 - u;
    u2 = (u * u) >> 16;
    a = 42048 - ((4640 * u2) >> 16);
    a = 102944 - ((a * u2) >> 16);
    s = (a * u) >> 16;
    m = (decay_gain(dt, c.fall_or_decay) * s) >> 16;
    prod = amp * longint'(m);
    if (quad[1]) prod = -prod;
    return longint'(c.base_level) + ((prod + 32768) >>> 16);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] source_level(input cfg_t c,
                                                              input logic [TIME_W-1:0] t);
    longint v;
    v = c.wave_mode ? damped_sine(c, t) : trapezoid(c, t);
    return SAMPLE_W'(sat16(v));
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    error_count++;
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00}); pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_MODE:   shadow_cfg.wave_mode          = val[0];
      REG_BASE:   shadow_cfg.base_level         = val[15:0];
      REG_PEAK:   shadow_cfg.peak_level         = val[15:0];
      REG_DELAY:  shadow_cfg.start_delay        = val;
      REG_RISE:   shadow_cfg.rise_or_phase_step = val;
      REG_FALL:   shadow_cfg.fall_or_decay      = val;
      REG_WIDTH:  shadow_cfg.pulse_width        = val;
      default:    shadow_cfg.pulse_period       = val;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_ticks.size() != 0 || expected_levels.size() != 0) @(posedge clk);
  endtask

  task automatic queue_ticks(input int n, input logic [31:0] lo, input logic [31:0] hi);
    for (int i = 0; i < n; i++) pending_ticks.push_back($urandom_range(hi, lo));
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (tick_valid && tick_ready) begin
        expected_levels.push_back(source_level(shadow_cfg, time_tick));
        void'(pending_ticks.pop_front());
      end
      if (tick_valid && !tick_ready) begin
      end else if (gap_left > 0) begin
        gap_left   <= gap_left - 1;
        tick_valid <= 1'b0;
      end else if (pending_ticks.size() > (tick_valid && tick_ready ? 0 : 1) ||
                   (!(tick_valid && tick_ready) && pending_ticks.size() > 0 && !tick_valid)) begin
        tick_valid <= 1'b1;
        time_tick  <= (tick_valid && tick_ready) ? pending_ticks[0] : pending_ticks[0];
        if (burst_left == 0) begin
          burst_left <= $urandom_range(40, 1);
          if ($urandom_range(3, 0) == 0) gap_left <= $urandom_range(6, 1);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        tick_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (rst) begin
      level_ready <= 1'b0;
      stall_phase <= 0;
      hold_off    <= 0;
    end else if (hold_request && hold_off == 0) begin
      hold_off    <= 150;
      level_ready <= 1'b0;
    end else if (hold_off > 1) begin
      hold_off    <= hold_off - 1;
      level_ready <= 1'b0;
    end else begin
      hold_off    <= 0;
      stall_phase <= (stall_phase + 1) % 97;
      level_ready <= (stall_phase < 40) ? 1'b1 : ($urandom_range(3, 0) != 0);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && level_valid && level_ready) begin
      level_count++;
      if (expected_levels.size() == 0) begin
        report_mismatch($sformatf("unexpected level transfer %0d", level));
      end else begin
        if (level !== expected_levels[0])
          report_mismatch($sformatf("level got %0d want %0d", level, expected_levels[0]));
        void'(expected_levels.pop_front());
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (tick_valid && tick_ready) || (level_valid && level_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_MAX) begin
        $display("watchdog expired");
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic run_phase(input cfg_t c, input int n);
    reg_write(REG_MODE, {31'd0, c.wave_mode});
    reg_write(REG_BASE, {16'($urandom_range(65535, 0)), c.base_level});
    reg_write(REG_PEAK, {16'd0, c.peak_level});
    reg_write(REG_DELAY, c.start_delay);
    reg_write(REG_RISE, c.rise_or_phase_step);
    reg_write(REG_FALL, c.fall_or_decay);
    reg_write(REG_WIDTH, c.pulse_width);
    reg_write(REG_PERIOD, c.pulse_period);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(5, 0))
        0: pending_ticks.push_back($urandom());
        1: pending_ticks.push_back(c.start_delay + $urandom_range(3, 0) - 1);
        default: pending_ticks.push_back(c.start_delay + $urandom_range(4000, 0));
      endcase
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    phase_count++;
  endtask

  function automatic cfg_t random_cfg(input bit mode);
    cfg_t c;
    c.wave_mode  = mode;
    c.base_level = 16'($urandom());
    c.peak_level = 16'($urandom());
    c.start_delay = ($urandom_range(3, 0) == 0) ? $urandom() : $urandom_range(200, 0);
    if (mode) begin
      c.rise_or_phase_step = $urandom();
      c.fall_or_decay      = $urandom_range(1, 0) ? $urandom_range(600, 0) : $urandom();
    end else begin
      c.rise_or_phase_step = $urandom_range(3, 0) == 0 ? 0 : $urandom_range(300, 1);
      c.fall_or_decay      = $urandom_range(3, 0) == 0 ? 0 : $urandom_range(300, 1);
    end
    c.pulse_width  = $urandom_range(400, 0);
    c.pulse_period = $urandom_range(1, 0) ? 0 : $urandom_range(1200, 1);
    return c;
  endfunction

  initial begin
    cfg_t c;
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    time_tick = '0;
    hold_request = 1'b0;
    shadow_cfg = '0;
    error_count = 0; level_count = 0; phase_count = 0; idle_cycles = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: reset settings, extremes of time
    pending_ticks.push_back(32'd0);
    pending_ticks.push_back(32'hFFFFFFFF);
    pending_ticks.push_back(32'h80000000);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    // trapezoid with ramps, extreme levels, time around the delay
    c = '0;
    c.base_level = 16'sh8000; c.peak_level = 16'sh7FFF; c.start_delay = 10;
    c.rise_or_phase_step = 5; c.fall_or_decay = 3; c.pulse_width = 4;
    run_phase(c, 6);
    for (int t = 8; t < 33; t++) pending_ticks.push_back(t);
    wait_drained();
    // jumps, period cut short, huge derived period
    c.rise_or_phase_step = 0; c.fall_or_decay = 0; c.pulse_period = 3;
    run_phase(c, 10);
    c.rise_or_phase_step = 32'hFFFFFFFF; c.fall_or_decay = 32'hFFFFFFFF;
    c.pulse_width = 32'hFFFFFFFF; c.pulse_period = 0; c.start_delay = 0;
    run_phase(c, 12);
    // sine extremes: no decay, full decay, maximum step
    c = '0;
    c.wave_mode = 1'b1; c.base_level = 16'sh7FFF; c.peak_level = 16'sh7FFF;
    c.rise_or_phase_step = 32'h40000000;
    run_phase(c, 16);
    c.base_level = 16'sh8000; c.peak_level = 16'sh8000;
    c.rise_or_phase_step = 32'hFFFFFFFF; c.fall_or_decay = 32'hFFFFFFFF;
    c.start_delay = 32'hFFFFFFFF;
    run_phase(c, 8);

    // random phases, with a long receiver hold-off in one of them
    while (level_count < 1150) begin
      c = random_cfg($urandom_range(1, 0));
      if (phase_count == 9) begin
        hold_request <= 1'b1;
        @(posedge clk);
        hold_request <= 1'b0;
      end
      run_phase(c, $urandom_range(120, 40));
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d level transfers over %0d register settings", level_count,
             phase_count);
    $display("both waveform shapes, delay edges, zero ramps and decay extremes exercised");
    if (error_count == 0 && expected_levels.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
